>>> design/ubin_pkg.sv
// shared constants, codes and types of the triangle binner
package ubin_pkg;

   // grid and store geometry
   localparam int GRID_MAX       = 64;
   localparam int POOL_BLOCKS    = 4096;
   localparam int MAX_CANDIDATES = 64;
   localparam int BLOCK_WORDS    = 8;
   localparam int BLOCK_SLOTS    = 7;
   localparam int HEAD_BLOCKS    = GRID_MAX * GRID_MAX;
   localparam int TOTAL_BLOCKS   = HEAD_BLOCKS + POOL_BLOCKS;
   localparam int STORE_DEPTH    = TOTAL_BLOCKS * BLOCK_WORDS;

   // widths
   localparam int GRID_W     = $clog2(GRID_MAX);
   localparam int WSEL_W     = $clog2(BLOCK_WORDS);
   localparam int BLK_W      = $clog2(TOTAL_BLOCKS);
   localparam int NFB_W      = $clog2(TOTAL_BLOCKS + 1);
   localparam int HEAD_W     = $clog2(HEAD_BLOCKS);
   localparam int ADDR_W     = BLK_W + WSEL_W;
   localparam int ID_W       = 20;
   localparam int WORD_W     = ID_W + 1;
   localparam int COORD_W    = 32;
   localparam int BND_W      = COORD_W + 2;
   localparam int DIFF_W     = BND_W + 1;
   localparam int UD_W       = BND_W;
   localparam int HALF_W     = 16;
   localparam int PROD_W     = UD_W + HALF_W;
   localparam int GC_W       = 7;
   localparam int IDX_W      = GC_W;
   localparam int MARGIN_W   = 31;
   localparam int NCAND_W    = $clog2(MAX_CANDIDATES + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int STATUS_W   = 2;

   // request opcodes
   localparam logic OPC_INSERT = 1'b0;
   localparam logic OPC_QUERY  = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DROPPED = 2'd1,
      STATUS_TRUNC   = 2'd2
   } status_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_CELL_SCALE = 3'd2,
      CSR_GRID_CELLS = 3'd3,
      CSR_BOX_MARGIN = 3'd4
   } csr_index_type;

   // datapath commands
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_CAPTURE,
      OP_BOX,
      OP_SUB,
      OP_MLO,
      OP_MHI,
      OP_RANGE,
      OP_RD_HEAD,
      OP_APPEND,
      OP_WR_CNT,
      OP_WR_NEW0,
      OP_WR_NEW1,
      OP_NEXT_CELL,
      OP_Q_LATCH,
      OP_RD_ID,
      OP_EMIT,
      OP_TRUNC,
      OP_FOLLOW,
      OP_FINISH
   } dp_op_type;

   // controller states
   typedef enum logic [4:0] {
      ST_CLR,
      ST_IDLE,
      ST_BOX,
      ST_SUB,
      ST_MLO,
      ST_MHI,
      ST_RANGE,
      ST_DISPATCH,
      ST_A_RD,
      ST_A_W0,
      ST_A_WCNT,
      ST_A_L1,
      ST_A_L2,
      ST_NEXT,
      ST_Q_RD0,
      ST_Q_W0,
      ST_Q_CHK,
      ST_Q_ID,
      ST_FIN
   } ctrl_state_type;

   // datapath status toward the controller
   typedef struct packed {
      logic is_query;
      logic clr_last;
      logic ix_last;
      logic none;
      logic ap_link;
      logic ap_link_bad;
      logic ap_full;
      logic pool_empty;
      logic more_slots;
      logic n_full;
      logic link_ok;
      logic more_cells;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage

>>> design/ubin_ram.sv
// generic simple dual port ram with registered read
module ubin_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ubin_ctrl.sv
// controller state machine of the triangle binner
module ubin_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  ubin_pkg::dp_status_type status,
   output ubin_pkg::dp_op_type    op,
   output logic                   busy
);
   import ubin_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register, clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_BOX;
         end
         ST_BOX:  state_in = ST_SUB;
         ST_SUB:  state_in = ST_MLO;
         ST_MLO:  state_in = ST_MHI;
         ST_MHI:  state_in = status.ix_last ? ST_RANGE : ST_SUB;
         ST_RANGE: state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            priority if (status.none) state_in = ST_FIN;
            else if (status.is_query) state_in = ST_Q_RD0;
            else state_in = ST_A_RD;
         end
         ST_A_RD: state_in = ST_A_W0;
         ST_A_W0: begin
            priority if (status.ap_link && !status.ap_link_bad) state_in = ST_A_RD;
            else if (status.ap_link) state_in = ST_NEXT;
            else if (!status.ap_full) state_in = ST_A_WCNT;
            else if (status.pool_empty) state_in = ST_NEXT;
            else state_in = ST_A_L1;
         end
         ST_A_WCNT: state_in = ST_NEXT;
         ST_A_L1:   state_in = ST_A_L2;
         ST_A_L2:   state_in = ST_NEXT;
         ST_NEXT:   state_in = status.more_cells ? ST_A_RD : ST_FIN;
         ST_Q_RD0:  state_in = ST_Q_W0;
         ST_Q_W0:   state_in = ST_Q_CHK;
         ST_Q_CHK: begin
            priority if (status.more_slots && status.n_full) state_in = ST_FIN;
            else if (status.more_slots) state_in = ST_Q_ID;
            else if (status.link_ok) state_in = ST_Q_RD0;
            else state_in = ST_FIN;
         end
         ST_Q_ID: begin
            if (!status.pend_valid || status.out_free) state_in = ST_Q_CHK;
         end
         ST_FIN: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      op = OP_NONE;
      unique case (state_ff)
         ST_CLR:  op = OP_CLEAR;
         ST_IDLE: begin
            if (req_valid) op = OP_CAPTURE;
         end
         ST_BOX:      op = OP_BOX;
         ST_SUB:      op = OP_SUB;
         ST_MLO:      op = OP_MLO;
         ST_MHI:      op = OP_MHI;
         ST_RANGE:    op = OP_RANGE;
         ST_DISPATCH: op = OP_NONE;
         ST_A_RD:     op = OP_RD_HEAD;
         ST_A_W0:     op = OP_APPEND;
         ST_A_WCNT:   op = OP_WR_CNT;
         ST_A_L1:     op = OP_WR_NEW0;
         ST_A_L2:     op = OP_WR_NEW1;
         ST_NEXT: begin
            if (status.more_cells) op = OP_NEXT_CELL;
         end
         ST_Q_RD0: op = OP_RD_HEAD;
         ST_Q_W0:  op = OP_Q_LATCH;
         ST_Q_CHK: begin
            priority if (status.more_slots && status.n_full) op = OP_TRUNC;
            else if (status.more_slots) op = OP_RD_ID;
            else if (status.link_ok) op = OP_FOLLOW;
            else op = OP_NONE;
         end
         ST_Q_ID: begin
            if (!status.pend_valid || status.out_free) op = OP_EMIT;
         end
         ST_FIN: begin
            if (status.out_free) op = OP_FINISH;
         end
         default: op = OP_NONE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> design/ubin_dp.sv
// datapath of the triangle binner: cell index unit, chain walker, result register
module ubin_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  ubin_pkg::dp_op_type              op,
   output ubin_pkg::dp_status_type          status,
   input  logic                             csr_wr_en,
   input  logic [ubin_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ubin_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_opcode,
   input  logic [ubin_pkg::ID_W-1:0]        req_tri_id,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_ax,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_ay,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_bx,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_by_coord,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_cx,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_cy,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [ubin_pkg::ID_W-1:0]        rsp_candidate_id,
   output logic                             rsp_has_candidate,
   output logic                             rsp_last_result,
   output logic [ubin_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             ram_wr_en,
   output logic [ubin_pkg::ADDR_W-1:0]      ram_wr_addr,
   output logic [ubin_pkg::WORD_W-1:0]      ram_wr_data,
   output logic                             ram_rd_en,
   output logic [ubin_pkg::ADDR_W-1:0]      ram_rd_addr,
   input  logic [ubin_pkg::WORD_W-1:0]      ram_rd_data
);
   import ubin_pkg::*;

   function automatic logic signed [COORD_W-1:0] min3(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b,
                                                      input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [COORD_W-1:0] max3(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b,
                                                      input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // configuration
   logic signed [COORD_W-1:0] origin_x_ff, origin_y_ff;
   logic [CSR_DATA_W-1:0]     cell_scale_ff;
   logic [GC_W-1:0]           grid_cells_ff;
   logic [MARGIN_W-1:0]       box_margin_ff;

   // captured item
   logic                      is_query_ff;
   logic [ID_W-1:0]           id_ff;
   logic signed [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;

   // index unit
   logic signed [BND_W-1:0]   bnd_ff [4];
   logic [1:0]                k_ix_ff;
   logic signed [DIFF_W-1:0]  d_ff;
   logic                      neg_ff;
   logic [PROD_W-1:0]         t_ff;
   logic [IDX_W-1:0]          idx_val_ff [4];
   logic                      idx_neg_ff [4];

   // cell walk
   logic [GRID_W-1:0]         i_ff, j_ff, jlo_ff, ihi_ff, jhi_ff;
   logic                      none_ff;
   logic [BLK_W-1:0]          blk_ff;
   logic [WORD_W-1:0]         w0_ff;
   logic [WSEL_W-1:0]         k_ff;
   logic [NFB_W-1:0]          nfb_ff;
   logic [HEAD_W-1:0]         clr_ff;
   logic                      pend_valid_ff;
   logic [ID_W-1:0]           pend_id_ff;
   logic [NCAND_W-1:0]        n_ff;
   logic                      trunc_ff;
   status_type                st_ff;

   // result register
   logic                      rsp_valid_ff;
   logic [ID_W-1:0]           rsp_id_ff;
   logic                      rsp_has_ff;
   logic                      rsp_last_ff;
   status_type                rsp_status_ff;

   // combinational terms
   logic signed [BND_W-1:0]   margin_ext;
   logic signed [COORD_W-1:0] xmin, xmax, ymin, ymax;
   logic signed [BND_W-1:0]   bnd_sel;
   logic signed [COORD_W-1:0] org_sel;
   logic signed [DIFF_W-1:0]  d_in;
   logic [PROD_W:0]           a_sum;
   logic [IDX_W-1:0]          idx_sat;
   logic [GC_W-1:0]           gc, gcm1;
   logic [IDX_W-1:0]          lo_x, hi_x, lo_y, hi_y;
   logic                      q_outside, i_empty;
   logic [WSEL_W-1:0]         cnt_q;
   logic                      ap_link, ap_link_bad, ap_full, pool_empty;
   logic                      out_free, rsp_load;
   logic [WSEL_W-1:0]         rd_word;

   // box widening and bounds
   assign margin_ext = $signed({{(BND_W-MARGIN_W){1'b0}}, box_margin_ff});
   assign xmin = min3(ax_ff, bx_ff, cx_ff);
   assign xmax = max3(ax_ff, bx_ff, cx_ff);
   assign ymin = min3(ay_ff, by_ff, cy_ff);
   assign ymax = max3(ay_ff, by_ff, cy_ff);

   // offset from origin
   assign bnd_sel = bnd_ff[k_ix_ff];
   assign org_sel = k_ix_ff[1] ? origin_y_ff : origin_x_ff;
   assign d_in    = {bnd_sel[BND_W-1], bnd_sel}
                  - {{(DIFF_W-COORD_W){org_sel[COORD_W-1]}}, org_sel};

   // high half product plus carried low half, saturated cell index
   assign a_sum   = (PROD_W+1)'(PROD_W'(d_ff[UD_W-1:0]) * PROD_W'(cell_scale_ff[CSR_DATA_W-1:HALF_W]))
                  + (PROD_W+1)'(t_ff[PROD_W-1:HALF_W]);
   assign idx_sat = (|a_sum[PROD_W:HALF_W+IDX_W]) ? {IDX_W{1'b1}} : a_sum[HALF_W+IDX_W-1:HALF_W];

   // clamping to the grid in use
   assign gc        = (grid_cells_ff > GC_W'(GRID_MAX)) ? GC_W'(GRID_MAX) : grid_cells_ff;
   assign gcm1      = gc - GC_W'(1);
   assign lo_x      = idx_neg_ff[0] ? '0 : idx_val_ff[0];
   assign hi_x      = (idx_val_ff[1] > gcm1) ? gcm1 : idx_val_ff[1];
   assign lo_y      = idx_neg_ff[2] ? '0 : idx_val_ff[2];
   assign hi_y      = (idx_val_ff[3] > gcm1) ? gcm1 : idx_val_ff[3];
   assign q_outside = (gc == '0) || idx_neg_ff[0] || idx_neg_ff[2]
                    || (idx_val_ff[0] >= gc) || (idx_val_ff[2] >= gc);
   assign i_empty   = (gc == '0) || idx_neg_ff[1] || idx_neg_ff[3]
                    || (lo_x > hi_x) || (lo_y > hi_y);

   // block header decode
   assign ap_link     = ram_rd_data[ID_W];
   assign ap_link_bad = ram_rd_data[ID_W-1:0] >= ID_W'(TOTAL_BLOCKS);
   assign ap_full     = ram_rd_data[WSEL_W-1:0] == WSEL_W'(BLOCK_SLOTS);
   assign pool_empty  = nfb_ff >= NFB_W'(TOTAL_BLOCKS);
   assign cnt_q       = w0_ff[ID_W] ? WSEL_W'(BLOCK_SLOTS) : w0_ff[WSEL_W-1:0];
   assign rd_word     = k_ff + WSEL_W'(1);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = ((op == OP_EMIT) && pend_valid_ff) || (op == OP_FINISH);

   // status toward the controller
   always_comb begin
      status.is_query    = is_query_ff;
      status.clr_last    = clr_ff == HEAD_W'(HEAD_BLOCKS - 1);
      status.ix_last     = k_ix_ff == 2'd3;
      status.none        = none_ff;
      status.ap_link     = ap_link;
      status.ap_link_bad = ap_link_bad;
      status.ap_full     = ap_full;
      status.pool_empty  = pool_empty;
      status.more_slots  = k_ff < cnt_q;
      status.n_full      = n_ff == NCAND_W'(MAX_CANDIDATES);
      status.link_ok     = w0_ff[ID_W] && (w0_ff[ID_W-1:0] < ID_W'(TOTAL_BLOCKS));
      status.more_cells  = (j_ff < jhi_ff) || (i_ff < ihi_ff);
      status.pend_valid  = pend_valid_ff;
      status.out_free    = out_free;
   end

   // store read port
   assign ram_rd_en   = (op == OP_RD_HEAD) || (op == OP_RD_ID);
   assign ram_rd_addr = (op == OP_RD_ID) ? {blk_ff, rd_word} : {blk_ff, WSEL_W'(0)};

   // store write port
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = {blk_ff, WSEL_W'(0)};
      ram_wr_data = '0;
      unique case (op)
         OP_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {BLK_W'(clr_ff), WSEL_W'(0)};
         end
         OP_APPEND: begin
            if (!ap_link && !ap_full) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = {blk_ff, ram_rd_data[WSEL_W-1:0] + WSEL_W'(1)};
               ram_wr_data = WORD_W'(id_ff);
            end else if (!ap_link && !pool_empty) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {1'b1, ID_W'(nfb_ff)};
            end
         end
         OP_WR_CNT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = WORD_W'(w0_ff[WSEL_W-1:0] + WSEL_W'(1));
         end
         OP_WR_NEW0: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {nfb_ff[BLK_W-1:0], WSEL_W'(0)};
            ram_wr_data = WORD_W'(1);
         end
         OP_WR_NEW1: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {nfb_ff[BLK_W-1:0], WSEL_W'(1)};
            ram_wr_data = WORD_W'(id_ff);
         end
         default: ram_wr_en = 1'b0;
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         cell_scale_ff <= CSR_DATA_W'(65536);
         grid_cells_ff <= GC_W'(1);
         box_margin_ff <= '0;
         clr_ff        <= '0;
         nfb_ff        <= NFB_W'(HEAD_BLOCKS);
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ORIGIN_X:   origin_x_ff   <= $signed(csr_wdata);
               CSR_ORIGIN_Y:   origin_y_ff   <= $signed(csr_wdata);
               CSR_CELL_SCALE: cell_scale_ff <= csr_wdata;
               CSR_GRID_CELLS: grid_cells_ff <= csr_wdata[GC_W-1:0];
               CSR_BOX_MARGIN: box_margin_ff <= csr_wdata[MARGIN_W-1:0];
               default: ;
            endcase
         end
         if (op == OP_CLEAR) clr_ff <= clr_ff + HEAD_W'(1);
         if (op == OP_WR_NEW1) nfb_ff <= nfb_ff + NFB_W'(1);
         if (op == OP_EMIT) pend_valid_ff <= 1'b1;
         else if (op == OP_FINISH) pend_valid_ff <= 1'b0;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (op)
         OP_CAPTURE: begin
            is_query_ff <= req_opcode;
            id_ff       <= req_tri_id;
            ax_ff       <= req_ax;
            ay_ff       <= req_ay;
            bx_ff       <= req_bx;
            by_ff       <= req_by_coord;
            cx_ff       <= req_cx;
            cy_ff       <= req_cy;
            k_ix_ff     <= '0;
            n_ff        <= '0;
            trunc_ff    <= 1'b0;
            st_ff       <= STATUS_OK;
         end
         OP_BOX: begin
            if (is_query_ff) begin
               bnd_ff[0] <= {{(BND_W-COORD_W){ax_ff[COORD_W-1]}}, ax_ff};
               bnd_ff[1] <= {{(BND_W-COORD_W){ax_ff[COORD_W-1]}}, ax_ff};
               bnd_ff[2] <= {{(BND_W-COORD_W){ay_ff[COORD_W-1]}}, ay_ff};
               bnd_ff[3] <= {{(BND_W-COORD_W){ay_ff[COORD_W-1]}}, ay_ff};
            end else begin
               bnd_ff[0] <= {{(BND_W-COORD_W){xmin[COORD_W-1]}}, xmin} - margin_ext;
               bnd_ff[1] <= {{(BND_W-COORD_W){xmax[COORD_W-1]}}, xmax} + margin_ext;
               bnd_ff[2] <= {{(BND_W-COORD_W){ymin[COORD_W-1]}}, ymin} - margin_ext;
               bnd_ff[3] <= {{(BND_W-COORD_W){ymax[COORD_W-1]}}, ymax} + margin_ext;
            end
         end
         OP_SUB: begin
            d_ff   <= d_in;
            neg_ff <= d_in[DIFF_W-1] && (cell_scale_ff != '0);
         end
         OP_MLO: begin
            t_ff <= PROD_W'(d_ff[UD_W-1:0]) * PROD_W'(cell_scale_ff[HALF_W-1:0]);
         end
         OP_MHI: begin
            idx_val_ff[k_ix_ff] <= d_ff[DIFF_W-1] ? '0 : idx_sat;
            idx_neg_ff[k_ix_ff] <= neg_ff;
            k_ix_ff             <= k_ix_ff + 2'd1;
         end
         OP_RANGE: begin
            none_ff <= is_query_ff ? q_outside : i_empty;
            if (is_query_ff) begin
               i_ff   <= idx_val_ff[0][GRID_W-1:0];
               j_ff   <= idx_val_ff[2][GRID_W-1:0];
               blk_ff <= {{(BLK_W-2*GRID_W){1'b0}}, idx_val_ff[0][GRID_W-1:0],
                          idx_val_ff[2][GRID_W-1:0]};
            end else begin
               i_ff   <= lo_x[GRID_W-1:0];
               j_ff   <= lo_y[GRID_W-1:0];
               blk_ff <= {{(BLK_W-2*GRID_W){1'b0}}, lo_x[GRID_W-1:0], lo_y[GRID_W-1:0]};
            end
            jlo_ff <= lo_y[GRID_W-1:0];
            ihi_ff <= hi_x[GRID_W-1:0];
            jhi_ff <= hi_y[GRID_W-1:0];
         end
         OP_APPEND: begin
            w0_ff <= ram_rd_data;
            if (ap_link && !ap_link_bad) blk_ff <= ram_rd_data[BLK_W-1:0];
            if ((ap_link && ap_link_bad) || (!ap_link && ap_full && pool_empty)) begin
               st_ff <= STATUS_DROPPED;
            end
         end
         OP_NEXT_CELL: begin
            if (j_ff < jhi_ff) begin
               j_ff   <= j_ff + GRID_W'(1);
               blk_ff <= {{(BLK_W-2*GRID_W){1'b0}}, i_ff, j_ff + GRID_W'(1)};
            end else begin
               i_ff   <= i_ff + GRID_W'(1);
               j_ff   <= jlo_ff;
               blk_ff <= {{(BLK_W-2*GRID_W){1'b0}}, i_ff + GRID_W'(1), jlo_ff};
            end
         end
         OP_Q_LATCH: begin
            w0_ff <= ram_rd_data;
            k_ff  <= '0;
         end
         OP_EMIT: begin
            pend_id_ff <= ram_rd_data[ID_W-1:0];
            n_ff       <= n_ff + NCAND_W'(1);
            k_ff       <= k_ff + WSEL_W'(1);
         end
         OP_TRUNC:  trunc_ff <= 1'b1;
         OP_FOLLOW: blk_ff   <= w0_ff[BLK_W-1:0];
         default: ;
      endcase

      // result register load
      if (op == OP_EMIT && pend_valid_ff) begin
         rsp_id_ff     <= pend_id_ff;
         rsp_has_ff    <= 1'b1;
         rsp_last_ff   <= 1'b0;
         rsp_status_ff <= STATUS_OK;
      end else if (op == OP_FINISH) begin
         rsp_id_ff     <= pend_valid_ff ? pend_id_ff : '0;
         rsp_has_ff    <= pend_valid_ff;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= pend_valid_ff ? (trunc_ff ? STATUS_TRUNC : STATUS_OK) : st_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_candidate_id  = rsp_id_ff;
   assign rsp_has_candidate = rsp_has_ff;
   assign rsp_last_result   = rsp_last_ff;
   assign rsp_status        = rsp_status_ff;

   // checks
   a_cand_bound: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (n_ff <= NCAND_W'(MAX_CANDIDATES)))
      else $error("candidate count beyond limit");

   a_pool_range: assert property (@(posedge clock) disable iff (reset)
      (nfb_ff >= NFB_W'(HEAD_BLOCKS)) && (nfb_ff <= NFB_W'(TOTAL_BLOCKS)))
      else $error("free block pointer out of pool");

   a_pend_query: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> is_query_ff)
      else $error("pending candidate during insert");

   a_cand_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_has_ff) |-> (rsp_status_ff != STATUS_DROPPED))
      else $error("candidate carries drop status");

   a_mid_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_status_ff == STATUS_OK))
      else $error("non-final result carries status");

endmodule

>>> design/uniform_grid_triangle_binner_top.sv
// Triangle binner over a uniform 2D grid with chained bucket blocks.
// Items run one at a time. Setup of an item computes the box, then four cell indices
// through a shared two-step 34x16 multiplier, then the range and dispatch.
// Insert walks each covered cell's chain block by block, then appends to a free slot or
// links and fills a new overflow block; query reads each block, then each candidate id.
// The final result comes after the walk; the store has a single write port and a single read port.
// After reset a clearing pass zeroes the 4096 head blocks; no items meanwhile.
module uniform_grid_triangle_binner_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ubin_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ubin_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [ubin_pkg::ID_W-1:0]           req_tri_id,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_ax,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_ay,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_bx,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_by_coord,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_cx,
   input  logic signed [ubin_pkg::COORD_W-1:0] req_cy,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ubin_pkg::ID_W-1:0]           rsp_candidate_id,
   output logic                                rsp_has_candidate,
   output logic                                rsp_last_result,
   output logic [ubin_pkg::STATUS_W-1:0]       rsp_status
);
   import ubin_pkg::*;

   dp_op_type         op;
   dp_status_type     status;
   logic              busy;
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0] ram_wr_data, ram_rd_data;

   // input side stalls whenever an item is in flight or the clearing pass runs
   assign req_stall = busy;

   // controller
   ubin_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .op        (op),
      .busy      (busy)
   );

   // datapath
   ubin_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_opcode        (req_opcode),
      .req_tri_id        (req_tri_id),
      .req_ax            (req_ax),
      .req_ay            (req_ay),
      .req_bx            (req_bx),
      .req_by_coord      (req_by_coord),
      .req_cx            (req_cx),
      .req_cy            (req_cy),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_candidate_id  (rsp_candidate_id),
      .rsp_has_candidate (rsp_has_candidate),
      .rsp_last_result   (rsp_last_result),
      .rsp_status        (rsp_status),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data)
   );

   // block store
   ubin_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

>>> dv/ubin_checker.sv
// result checker for the triangle binner: tracks the grid store and compares every transfer
module ubin_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [ubin_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ubin_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [ubin_pkg::ID_W-1:0]            req_tri_id,
   input  logic signed [ubin_pkg::COORD_W-1:0]  req_ax,
   input  logic signed [ubin_pkg::COORD_W-1:0]  req_ay,
   input  logic signed [ubin_pkg::COORD_W-1:0]  req_bx,
   input  logic signed [ubin_pkg::COORD_W-1:0]  req_by_coord,
   input  logic signed [ubin_pkg::COORD_W-1:0]  req_cx,
   input  logic signed [ubin_pkg::COORD_W-1:0]  req_cy,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [ubin_pkg::ID_W-1:0]            rsp_candidate_id,
   input  logic                                 rsp_has_candidate,
   input  logic                                 rsp_last_result,
   input  logic [ubin_pkg::STATUS_W-1:0]        rsp_status,
   output int                                   fail_count,
   output int                                   outstanding
);
   import ubin_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [ID_W-1:0]     id;
      logic                has;
      logic                last;
      logic [STATUS_W-1:0] st;
   } cand_type;

   // mirror of the bucket store and the register file
   logic [WORD_W-1:0] bucket_mem [STORE_DEPTH];
   int                free_blk;
   longint            org_x, org_y, margin;
   logic [31:0]       scale;
   logic [GC_W-1:0]   cells;
   cand_type          cand_q[$];

   // cell index along one axis, -1 for anything below the origin unless the scale is zero
   function automatic longint cell_of(longint p, longint org);
      longint      d;
      logic [95:0] prod;
      d = p - org;
      if (d < 0) return (scale == 0) ? 0 : -1;
      prod = 96'(d) * 96'(scale);
      return longint'(prod[95:32]);
   endfunction

   // append one id to a cell chain, 0 when the pool has run dry or a link is out of range
   function automatic bit bucket_append(int head_blk, logic [ID_W-1:0] id);
      int                blk;
      int                cnt;
      logic [WORD_W-1:0] w;
      blk = head_blk;
      for (int n = 0; n <= TOTAL_BLOCKS; n++) begin
         w = bucket_mem[blk*BLOCK_WORDS];
         if (w[ID_W]) begin
            if (int'(w[ID_W-1:0]) >= TOTAL_BLOCKS) return 0;
            blk = int'(w[ID_W-1:0]);
            continue;
         end
         cnt = int'(w[2:0]);
         if (cnt < BLOCK_SLOTS) begin
            bucket_mem[blk*BLOCK_WORDS+cnt+1] = {1'b0, id};
            bucket_mem[blk*BLOCK_WORDS]       = WORD_W'(cnt + 1);
            return 1;
         end
         if (free_blk >= TOTAL_BLOCKS) return 0;
         bucket_mem[blk*BLOCK_WORDS]        = {1'b1, ID_W'(free_blk)};
         bucket_mem[free_blk*BLOCK_WORDS]   = WORD_W'(1);
         bucket_mem[free_blk*BLOCK_WORDS+1] = {1'b0, id};
         free_blk++;
         return 1;
      end
      return 0;
   endfunction

   // work out the results of one request transfer
   task automatic predict_bin();
      longint            ax, ay, bx, by, cx, cy, ilo, ihi, jlo, jhi, gc, i, j;
      logic [STATUS_W-1:0] st;
      cand_type          c;
      cand_type          found[$];
      int                blk, cnt;
      logic [WORD_W-1:0] w;
      bit                trunc, done;
      ax = req_ax; ay = req_ay; bx = req_bx; by = req_by_coord; cx = req_cx; cy = req_cy;
      gc = (cells > GRID_MAX) ? GRID_MAX : cells;
      c = '{id: '0, has: 1'b0, last: 1'b1, st: STATUS_OK};
      if (req_opcode != OPC_QUERY) begin
         st  = STATUS_OK;
         ilo = cell_of(((ax < bx) ? ((ax < cx) ? ax : cx) : ((bx < cx) ? bx : cx)) - margin, org_x);
         ihi = cell_of(((ax > bx) ? ((ax > cx) ? ax : cx) : ((bx > cx) ? bx : cx)) + margin, org_x);
         jlo = cell_of(((ay < by) ? ((ay < cy) ? ay : cy) : ((by < cy) ? by : cy)) - margin, org_y);
         jhi = cell_of(((ay > by) ? ((ay > cy) ? ay : cy) : ((by > cy) ? by : cy)) + margin, org_y);
         if (gc > 0) begin
            if (ilo < 0) ilo = 0;
            if (jlo < 0) jlo = 0;
            if (ihi > gc - 1) ihi = gc - 1;
            if (jhi > gc - 1) jhi = gc - 1;
            for (i = ilo; i <= ihi; i++)
               for (j = jlo; j <= jhi; j++)
                  if (!bucket_append(int'(i*GRID_MAX + j), req_tri_id)) st = STATUS_DROPPED;
         end
         c.st = st;
         cand_q = {cand_q, c};
         return;
      end
      i = cell_of(ax, org_x);
      j = cell_of(ay, org_y);
      if (i < 0 || j < 0 || i >= gc || j >= gc) begin
         cand_q = {cand_q, c};
         return;
      end
      // walk the chain in order
      blk = int'(i*GRID_MAX + j);
      trunc = 0;
      done = 0;
      for (int n = 0; n <= TOTAL_BLOCKS && !done; n++) begin
         w = bucket_mem[blk*BLOCK_WORDS];
         cnt = w[ID_W] ? BLOCK_SLOTS : int'(w[2:0]);
         for (int k = 0; k < cnt; k++) begin
            if (found.size() >= MAX_CANDIDATES) begin
               trunc = 1;
               break;
            end
            found = {found, cand_type'{id: bucket_mem[blk*BLOCK_WORDS+1+k][ID_W-1:0],
                                       has: 1'b1, last: 1'b0, st: STATUS_OK}};
         end
         if (trunc || !w[ID_W] || int'(w[ID_W-1:0]) >= TOTAL_BLOCKS) done = 1;
         else blk = int'(w[ID_W-1:0]);
      end
      if (found.size() == 0) begin
         cand_q = {cand_q, c};
         return;
      end
      found[found.size()-1].last = 1'b1;
      if (trunc) found[found.size()-1].st = STATUS_TRUNC;
      cand_q = {cand_q, found};
   endtask

   // register writes, request and result transfers
   always @(posedge clock) begin
      cand_type e;
      if (reset) begin
         foreach (bucket_mem[k]) bucket_mem[k] = '0;
         free_blk = HEAD_BLOCKS;
         org_x = 0; org_y = 0; scale = 32'd65536; cells = 7'd1; margin = 0;
         cand_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ORIGIN_X:   org_x  = longint'(signed'(csr_wdata));
               CSR_ORIGIN_Y:   org_y  = longint'(signed'(csr_wdata));
               CSR_CELL_SCALE: scale  = csr_wdata;
               CSR_GRID_CELLS: cells  = csr_wdata[GC_W-1:0];
               CSR_BOX_MARGIN: margin = longint'(csr_wdata[MARGIN_W-1:0]);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_bin();
         if (rsp_valid && !rsp_stall) begin
            if (cand_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result transfer: id %h has %b last %b status %0d",
                           rsp_candidate_id, rsp_has_candidate, rsp_last_result, rsp_status);
            end else begin
               e = cand_q.pop_front();
               if (rsp_candidate_id !== e.id || rsp_has_candidate !== e.has ||
                   rsp_last_result !== e.last || rsp_status !== e.st) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: expected id %h has %b last %b status %0d, ",
                               "got id %h has %b last %b status %0d"},
                              e.id, e.has, e.last, e.st, rsp_candidate_id,
                              rsp_has_candidate, rsp_last_result, rsp_status);
               end
            end
         end
      end
      outstanding = cand_q.size();
   end

endmodule

>>> dv/tb.sv
// stimulus and verdict for the triangle binner
module tb;
   import ubin_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ONE        = 65536;
   localparam int LIMIT      = 4000000;

   typedef struct {
      bit                      op;
      logic [ID_W-1:0]         id;
      logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
   } bin_req_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = CSR_ORIGIN_X;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_opcode = OPC_INSERT;
   logic [ID_W-1:0]             req_tri_id = '0;
   logic signed [COORD_W-1:0]   req_ax = '0, req_ay = '0, req_bx = '0;
   logic signed [COORD_W-1:0]   req_by_coord = '0, req_cx = '0, req_cy = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [ID_W-1:0]             rsp_candidate_id;
   logic                        rsp_has_candidate;
   logic                        rsp_last_result;
   logic [STATUS_W-1:0]         rsp_status;
   int                          fail_count;
   int                          outstanding;
   int                          cycles = 0;
   int                          burst_left = 0;
   int                          hold_reqs = 0;

   uniform_grid_triangle_binner_top u_dut (.*);
   ubin_checker u_chk (.*);

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side stall pattern with one long hold-off on request
   initial begin
      int mode, span, hold, hold_seen;
      hold_seen = 0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(30, 200);
         repeat (span) begin
            @(negedge clock);
            if (hold_reqs != hold_seen) begin
               hold_seen = hold_reqs;
               hold = 2000;
               while (hold > 0) begin
                  rsp_stall = 1'b1;
                  hold--;
                  @(negedge clock);
               end
            end
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 3) == 0);
               default: rsp_stall = ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic grid_setup(logic [31:0] ox, logic [31:0] oy, logic [31:0] sc,
                             logic [31:0] gc, logic [31:0] mg);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_CELL_SCALE, sc);
      csr_write(CSR_GRID_CELLS, gc);
      csr_write(CSR_BOX_MARGIN, mg);
   endtask

   // one request transfer, with bursts and gaps
   task automatic send(bin_req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid = 1'b1;
      req_opcode = r.op;
      req_tri_id = r.id;
      req_ax = r.ax; req_ay = r.ay; req_bx = r.bx;
      req_by_coord = r.by; req_cx = r.cx; req_cy = r.cy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic bin_req_type noise_req();
      bin_req_type r;
      r.op = 1'($urandom_range(0, 1));
      r.id = ID_W'($urandom);
      r.ax = $urandom; r.ay = $urandom; r.bx = $urandom;
      r.by = $urandom; r.cx = $urandom; r.cy = $urandom;
      return r;
   endfunction

   // small triangle inside the box whose low corner is (x0, y0)
   function automatic bin_req_type tri_req(logic [ID_W-1:0] id, int x0, int y0, int spread);
      bin_req_type r;
      r = noise_req();
      r.op = OPC_INSERT;
      r.id = id;
      r.ax = x0 + $urandom_range(0, spread); r.ay = y0 + $urandom_range(0, spread);
      r.bx = x0 + $urandom_range(0, spread); r.by = y0 + $urandom_range(0, spread);
      r.cx = x0 + $urandom_range(0, spread); r.cy = y0 + $urandom_range(0, spread);
      return r;
   endfunction

   function automatic bin_req_type point_req(int x, int y);
      bin_req_type r;
      r = noise_req();
      r.op = OPC_QUERY;
      r.ax = x;
      r.ay = y;
      return r;
   endfunction

   initial begin
      bin_req_type r;
      int gcnt, ox, oy, span;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: unit cells on a 4x4 grid
      grid_setup(32'd0, 32'd0, 32'd65536, 32'd4, 32'd0);
      send(point_req(ONE + ONE/2, ONE + ONE/2));
      send(tri_req(20'hFFFFF, ONE/5, ONE/5, ONE/2));
      r = tri_req(20'd1, ONE/2, ONE/2, 0);
      r.bx = 3*ONE + ONE/2; r.cy = 3*ONE + ONE/2;
      send(r);
      send(tri_req(20'd2, -9*ONE, -9*ONE, ONE));
      r = tri_req(20'd3, ONE/2, ONE/2, 100);
      r.ax = 32'sh8000_0000; r.bx = 32'sh7FFF_FFFF;
      send(r);
      send(tri_req(20'd0, 2*ONE, 0, ONE));
      send(point_req(ONE/2, ONE/2));
      send(point_req(-ONE, ONE/2));
      send(point_req(10*ONE, 10*ONE));
      send(point_req(32'sh7FFF_FFFF, 32'sh8000_0000));
      send(point_req(2*ONE + 5, ONE/3));
      send(point_req(3*ONE, 3*ONE));
      drain();

      // zero scale, extreme origins and margin: all maps to cell zero
      grid_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd64, 32'h7FFF_FFFF);
      repeat (30) send(noise_req());
      drain();

      // maximum scale on an oversized grid: one cell per lsb
      ox = $urandom;
      oy = $urandom;
      grid_setup(ox, oy, 32'hFFFF_FFFF, 32'd127, $urandom_range(1, 3));
      repeat (30) begin
         if ($urandom_range(0, 1))
            send(tri_req(ID_W'($urandom), ox + $urandom_range(0, 80) - 4,
                         oy + $urandom_range(0, 80) - 4, 3));
         else
            send(point_req(ox + $urandom_range(0, 70), oy + $urandom_range(0, 70)));
      end
      drain();

      // no cells: everything lies outside
      grid_setup(32'd0, 32'd0, 32'd65536, 32'd0, 32'd0);
      repeat (6) send(noise_req());
      drain();

      // main random run, with the long result hold-off at its start
      gcnt = $urandom_range(2, 6);
      ox = -5*ONE;
      oy = 3*ONE;
      span = gcnt * 2 * ONE;
      grid_setup(ox, oy, 32'h0000_8000, gcnt, 32'd66);
      hold_reqs++;
      repeat (160) begin
         case ($urandom_range(0, 9))
            0, 1:    send(noise_req());
            2, 3, 4: send(point_req(ox - ONE + $urandom_range(0, span + 2*ONE),
                                    oy - ONE + $urandom_range(0, span + 2*ONE)));
            default: send(tri_req(ID_W'($urandom), ox - ONE/2 + $urandom_range(0, span),
                                  oy - ONE/2 + $urandom_range(0, span), 3*ONE/2));
         endcase
      end
      drain();

      // full-grid inserts until the overflow pool runs out
      grid_setup(32'd0, 32'd0, 32'd65536, 32'd64, 32'd0);
      repeat (10) begin
         r = tri_req(ID_W'($urandom), -ONE, -ONE, 0);
         r.bx = 100*ONE; r.cy = 100*ONE;
         send(r);
      end
      send(point_req(0, 0));
      repeat (4) send(point_req($urandom_range(0, 64*ONE - 1), $urandom_range(0, 64*ONE - 1)));
      drain();
      repeat (100) @(negedge clock);

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
